@@ src/imu_sfp_pkg.sv @@
package imu_sfp_pkg;

  localparam int unsigned PayloadBytes = 6;
  localparam int unsigned FifoDepthDef = 2;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] TypeAccel = 8'h51;
  localparam logic [7:0] TypeRate  = 8'h52;
  localparam logic [7:0] TypeAngle = 8'h53;

  localparam logic [1:0] CfgAngleGain = 2'd0;
  localparam logic [1:0] CfgAccelGain = 2'd1;
  localparam logic [1:0] CfgRateGain  = 2'd2;

  localparam logic [15:0] AngleGainRst = 16'd46080;
  localparam logic [15:0] AccelGainRst = 16'd40141;
  localparam logic [15:0] RateGainRst  = 16'd40141;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] gain;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
    logic [15:0] raw_z;
  } frame_t;

  typedef struct packed {
    logic   push;
    frame_t entry;
  } push_t;

  typedef struct packed {
    logic   empty;
    frame_t entry;
  } head_t;

endpackage

@@ src/imu_sfp_front.sv @@
module imu_sfp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 full_i,
  output imu_sfp_pkg::push_t   push_o
);
  import imu_sfp_pkg::*;

  localparam logic [1:0] PhHeader   = 2'd0;
  localparam logic [1:0] PhType     = 2'd1;
  localparam logic [1:0] PhPayload  = 2'd2;
  localparam logic [1:0] PhChecksum = 2'd3;

  localparam logic [2:0] LastIdx = 3'(PayloadBytes - 1);

  logic [1:0]  phase_q, phase_d;
  kind_e       kind_q, kind_d;
  logic [2:0]  idx_q, idx_d;
  logic [7:0]  data_q [PayloadBytes];
  logic [15:0] angle_gain_q, accel_gain_q, rate_gain_q;
  logic [15:0] gain_sel;
  logic        beat;
  logic [7:0]  rx_byte;

  assign rx_byte       = s_axis_tdata;
  assign s_axis_tready = !full_i;
  assign beat          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_gain_q <= AngleGainRst;
      accel_gain_q <= AccelGainRst;
      rate_gain_q  <= RateGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgAngleGain: angle_gain_q <= cfg_wdata_i;
        CfgAccelGain: accel_gain_q <= cfg_wdata_i;
        CfgRateGain:  rate_gain_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    if (beat) begin
      unique case (phase_q)
        PhHeader: begin
          if (rx_byte == HdrByte) phase_d = PhType;
        end
        PhType: begin
          if (rx_byte == TypeAccel || rx_byte == TypeRate || rx_byte == TypeAngle) begin
            kind_d  = kind_e'(2'(rx_byte - TypeAccel));
            idx_d   = '0;
            phase_d = PhPayload;
          end else begin
            phase_d = PhHeader;
          end
        end
        PhPayload: begin
          idx_d = idx_q + 3'd1;
          if (idx_q >= LastIdx) phase_d = PhChecksum;
        end
        default: begin
          phase_d = PhHeader;
          idx_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      kind_q  <= KIND_ACCEL;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && phase_q == PhPayload && idx_q <= LastIdx) begin
      data_q[idx_q] <= rx_byte;
    end
  end

  always_comb begin
    unique case (kind_q)
      KIND_ACCEL: gain_sel = accel_gain_q;
      KIND_RATE:  gain_sel = rate_gain_q;
      default:    gain_sel = angle_gain_q;
    endcase
  end

  assign push_o.push        = beat && phase_q == PhChecksum;
  assign push_o.entry.kind  = kind_q;
  assign push_o.entry.gain  = gain_sel;
  assign push_o.entry.raw_x = {data_q[1], data_q[0]};
  assign push_o.entry.raw_y = {data_q[3], data_q[2]};
  assign push_o.entry.raw_z = {data_q[5], data_q[4]};

endmodule

@@ src/imu_sfp_fifo.sv @@
module imu_sfp_fifo #(
  parameter int unsigned Depth = imu_sfp_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imu_sfp_pkg::push_t  push_i,
  output logic                full_o,
  input  logic                pop_i,
  output imu_sfp_pkg::head_t  head_o
);
  import imu_sfp_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  frame_t           mem_q [Depth];
  logic [AddrW:0]   wr_ptr_q, rd_ptr_q;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic             empty;

  assign wr_addr = wr_ptr_q[AddrW-1:0];
  assign rd_addr = rd_ptr_q[AddrW-1:0];
  assign empty   = wr_ptr_q == rd_ptr_q;
  assign full_o  = (wr_addr == rd_addr) && (wr_ptr_q[AddrW] != rd_ptr_q[AddrW]);

  assign head_o.empty = empty;
  assign head_o.entry = mem_q[rd_addr];

  always_ff @(posedge clk_i) begin
    if (push_i.push && !full_o) begin
      mem_q[wr_addr] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (push_i.push && !full_o) wr_ptr_q <= wr_ptr_q + {{AddrW{1'b0}}, 1'b1};
      if (pop_i && !empty)        rd_ptr_q <= rd_ptr_q + {{AddrW{1'b0}}, 1'b1};
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.push && full_o)) else $error("frame pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty)) else $error("frame popped from empty queue");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push && !pop_i) |=> !empty) else $error("queue empty after push");
  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !push_i.push) |=> !full_o) else $error("queue full after pop");
`endif

endmodule

@@ src/imu_sfp_back.sv @@
module imu_sfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imu_sfp_pkg::head_t  head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // [8:0] value_x, [17:9] value_y, [26:18] value_z
  output logic [1:0]          m_axis_tuser    // [1:0] frame_kind
);
  import imu_sfp_pkg::*;

  function automatic logic signed [8:0] scale_axis(input logic [15:0] raw,
                                                   input logic [15:0] gain);
    logic        neg;
    logic [15:0] mag;
    logic [31:0] prod;
    logic [8:0]  q;
    neg  = raw[15];
    mag  = neg ? 16'(~raw + 16'd1) : raw;
    prod = 32'(mag) * 32'(gain);
    q    = prod[31:23];
    return neg ? $signed(9'(~q + 9'd1)) : $signed(q);
  endfunction

  logic                valid_q;
  kind_e               kind_q;
  logic signed [8:0]   x_q, y_q, z_q;
  logic                load;

  assign load  = !head_i.empty && (!valid_q || m_axis_tready);
  assign pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.entry.kind;
      x_q    <= scale_axis(head_i.entry.raw_x, head_i.entry.gain);
      y_q    <= scale_axis(head_i.entry.raw_y, head_i.entry.gain);
      z_q    <= scale_axis(head_i.entry.raw_z, head_i.entry.gain);
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {5'd0, z_q, y_q, x_q};

endmodule

@@ src/imu_serial_frame_parser.sv @@
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata 3 x 9-bit values, tuser frame_kind
// cfg       in   cfg_we_i                      cfg_idx_i, cfg_wdata_i (16-bit gain)
//
// One byte is taken per cycle; the parser stalls only when the frame queue is full.
// The queue takes a frame on the edge that takes its checksum beat; the output register behind
// the three 16x16 scaling multipliers loads it from the queue head when that register is empty
// or its result is being taken, so a low m_axis_tready can hold the frame in the queue.
// Reset sets the gains to their defaults, the parser to header search and empties
// the queue; no clearing pass is needed.
module imu_serial_frame_parser #(
  parameter int unsigned FifoDepth = imu_sfp_pkg::FifoDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [8:0] value_x, [17:9] value_y, [26:18] value_z
  output logic [1:0]  m_axis_tuser,   // [1:0] frame_kind
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);
  import imu_sfp_pkg::*;

  push_t push;
  head_t head;
  logic  full;
  logic  pop;

  imu_sfp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .full_i        (full),
    .push_o        (push)
  );

  imu_sfp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  imu_sfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ tb/sv/tb_imu_serial_frame_parser.sv @@
`timescale 1ns / 1ps

module tb_imu_serial_frame_parser;
  import imu_sfp_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseBytes    = 235;
  localparam logic [1:0]  CfgSpareIdx   = 2'd3;

  typedef enum logic [1:0] {
    SEEK_HDR,
    SEEK_TYPE,
    TAKE_DATA,
    TAKE_SUM
  } parse_phase_e;

  typedef struct packed {
    kind_e             kind;
    logic signed [8:0] x;
    logic signed [8:0] y;
    logic signed [8:0] z;
  } imu_reading_t;

  typedef struct packed {
    logic [7:0]   rx;
    bit           typed;
    imu_reading_t want;
  } dir_row_t;

  localparam imu_reading_t NoReading = '{KIND_ACCEL, 9'sd0, 9'sd0, 9'sd0};

  localparam dir_row_t DirectedRows [30] = '{
    '{8'h55, 1'b0, NoReading},
    '{8'h53, 1'b0, NoReading},
    '{8'hFF, 1'b0, NoReading},
    '{8'h7F, 1'b0, NoReading},
    '{8'h00, 1'b0, NoReading},
    '{8'h80, 1'b0, NoReading},
    '{8'h00, 1'b0, NoReading},
    '{8'h00, 1'b0, NoReading},
    '{8'hFF, 1'b1, '{KIND_ANGLE, 9'sd179, -9'sd180, 9'sd0}},
    '{8'h55, 1'b0, NoReading},
    '{8'h55, 1'b0, NoReading},
    '{8'h51, 1'b0, NoReading},
    '{8'h55, 1'b0, NoReading},
    '{8'h51, 1'b0, NoReading},
    '{8'h00, 1'b0, NoReading},
    '{8'h80, 1'b0, NoReading},
    '{8'hFF, 1'b0, NoReading},
    '{8'h7F, 1'b0, NoReading},
    '{8'hFF, 1'b0, NoReading},
    '{8'hFF, 1'b0, NoReading},
    '{8'h00, 1'b1, '{KIND_ACCEL, -9'sd156, 9'sd156, 9'sd0}},
    '{8'h55, 1'b0, NoReading},
    '{8'h52, 1'b0, NoReading},
    '{8'h34, 1'b0, NoReading},
    '{8'h12, 1'b0, NoReading},
    '{8'hCC, 1'b0, NoReading},
    '{8'hED, 1'b0, NoReading},
    '{8'h00, 1'b0, NoReading},
    '{8'h40, 1'b0, NoReading},
    '{8'h55, 1'b0, NoReading}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CfgAngleGain;
  logic [15:0] cfg_wdata_i   = 16'h0000;

  parse_phase_e parse_phase   = SEEK_HDR;
  kind_e        latched_kind  = KIND_ACCEL;
  int unsigned  payload_count = 0;
  logic [7:0]   payload [PayloadBytes];
  logic [15:0]  angle_gain    = AngleGainRst;
  logic [15:0]  accel_gain    = AccelGainRst;
  logic [15:0]  rate_gain     = RateGainRst;

  imu_reading_t pending_readings [$];
  int unsigned  parsed_bytes   = 0;
  int unsigned  fail_count     = 0;
  int unsigned  feed_idle_pct  = 10;
  int unsigned  drain_idle_pct = 58;
  int unsigned  stall_cycles;

  imu_serial_frame_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [8:0] scale_axis(input logic [15:0] raw,
                                                   input logic [15:0] gain);
    logic [16:0] mag;
    logic [32:0] prod;
    logic [8:0]  q;
    mag  = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    prod = {16'b0, mag} * {17'b0, gain};
    q    = prod[31:23];
    return raw[15] ? (9'd0 - q) : q;
  endfunction

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic parse_step(input logic [7:0] rx, output bit ignored, output bit done,
                            output imu_reading_t got);
    logic [15:0] gain;
    ignored = 1'b0;
    done    = 1'b0;
    got     = NoReading;
    case (parse_phase)
      SEEK_HDR: begin
        ignored = (rx != HdrByte);
        if (!ignored) parse_phase = SEEK_TYPE;
      end
      SEEK_TYPE: begin
        parse_phase   = TAKE_DATA;
        payload_count = 0;
        case (rx)
          TypeAccel: latched_kind = KIND_ACCEL;
          TypeRate:  latched_kind = KIND_RATE;
          TypeAngle: latched_kind = KIND_ANGLE;
          default:   parse_phase = SEEK_HDR;
        endcase
      end
      TAKE_DATA: begin
        payload[payload_count] = rx;
        payload_count++;
        if (payload_count == PayloadBytes) parse_phase = TAKE_SUM;
      end
      default: begin
        case (latched_kind)
          KIND_ACCEL: gain = accel_gain;
          KIND_RATE:  gain = rate_gain;
          default:    gain = angle_gain;
        endcase
        got.kind    = latched_kind;
        got.x       = scale_axis({payload[1], payload[0]}, gain);
        got.y       = scale_axis({payload[3], payload[2]}, gain);
        got.z       = scale_axis({payload[5], payload[4]}, gain);
        done        = 1'b1;
        parse_phase = SEEK_HDR;
      end
    endcase
  endtask

  task automatic send_rx(input logic [7:0] rx, input bit typed = 1'b0,
                         input imu_reading_t want = NoReading);
    bit           ignored;
    bit           done;
    imu_reading_t got;
    while ($urandom_range(99) < feed_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_step(rx, ignored, done, got);
    if (!ignored) parsed_bytes++;
    if (done) pending_readings.push_back(typed ? want : got);
  endtask

  task automatic send_random_unit();
    logic [7:0]  rx;
    logic [15:0] raw;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      send_rx(HdrByte);
      case ($urandom_range(2))
        0: send_rx(TypeAccel);
        1: send_rx(TypeRate);
        default: send_rx(TypeAngle);
      endcase
      for (int a = 0; a < 3; a++) begin
        raw = pick_raw();
        send_rx(raw[7:0]);
        send_rx(raw[15:8]);
      end
      send_rx(8'($urandom_range(255)));
    end else if (pick < 85) begin
      // bad type byte; a random value that is a valid type is replaced by a second header
      rx = 8'($urandom_range(255));
      if (rx >= TypeAccel && rx <= TypeAngle) rx = HdrByte;
      send_rx(HdrByte);
      send_rx(rx);
    end else if (pick < 95) begin
      repeat ($urandom_range(4, 1)) send_rx(8'($urandom_range(255)));
    end else begin
      // cut frame: later bytes fill the rest
      send_rx(HdrByte);
      send_rx(8'(TypeAccel + $urandom_range(2)));
      repeat ($urandom_range(5)) send_rx(8'($urandom_range(255)));
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_gains(input logic [15:0] ang, input logic [15:0] acc,
                               input logic [15:0] rte);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgAngleGain;
    cfg_wdata_i <= ang;
    @(posedge clk_i);
    cfg_idx_i   <= CfgAccelGain;
    cfg_wdata_i <= acc;
    @(posedge clk_i);
    cfg_idx_i   <= CfgRateGain;
    cfg_wdata_i <= rte;
    @(posedge clk_i);
    // spare index: dropped by the block
    cfg_idx_i   <= CfgSpareIdx;
    cfg_wdata_i <= 16'($urandom_range(65535));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    angle_gain = ang;
    accel_gain = acc;
    rate_gain  = rte;
    @(posedge clk_i);
  endtask

  task automatic check_reading();
    imu_reading_t want;
    if (pending_readings.size() == 0) begin
      $error("frame_kind: expected none, got %0d", m_axis_tuser);
      fail_count++;
    end else begin
      want = pending_readings.pop_front();
      if (m_axis_tuser !== want.kind) begin
        $error("frame_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
        fail_count++;
      end
      if ($signed(m_axis_tdata[8:0]) !== want.x) begin
        $error("value_x: expected %0d, got %0d", want.x, $signed(m_axis_tdata[8:0]));
        fail_count++;
      end
      if ($signed(m_axis_tdata[17:9]) !== want.y) begin
        $error("value_y: expected %0d, got %0d", want.y, $signed(m_axis_tdata[17:9]));
        fail_count++;
      end
      if ($signed(m_axis_tdata[26:18]) !== want.z) begin
        $error("value_z: expected %0d, got %0d", want.z, $signed(m_axis_tdata[26:18]));
        fail_count++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_reading();
    m_axis_tready <= ($urandom_range(99) >= drain_idle_pct);
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i])
      send_rx(DirectedRows[i].rx, DirectedRows[i].typed, DirectedRows[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        feed_idle_pct  = 58;
        drain_idle_pct = 10;
      end
      if (ph == 4) begin
        feed_idle_pct  = 0;
        drain_idle_pct = 0;
      end
      if (ph != 0) begin
        settle();
        case (ph)
          1: program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
          2: program_gains(16'h0000, 16'h0000, 16'h0000);
          5: program_gains(16'hFFFF, 16'h0000, 16'($urandom_range(65535)));
          default: program_gains(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)));
        endcase
      end
      parsed_bytes = 0;
      while (parsed_bytes < PhaseBytes) send_random_unit();
    end

    settle();
    if (fail_count == 0 && pending_readings.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
src/imu_sfp_pkg.sv
src/imu_sfp_front.sv
src/imu_sfp_fifo.sv
src/imu_sfp_back.sv
src/imu_serial_frame_parser.sv
tb/sv/tb_imu_serial_frame_parser.sv
